[src/box_frustum_visibility_test_unit_macros.svh]
// Assertion macros shared by the visibility test RTL.
`ifndef BOX_FRUSTUM_VISIBILITY_TEST_UNIT_MACROS_SVH
`define BOX_FRUSTUM_VISIBILITY_TEST_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BFVT_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check a consequence in the cycle after its antecedent.
`define BFVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/bfvt_pkg.sv]
// Package with types and constants of the box frustum visibility test unit.
package bfvt_pkg;

    localparam int COORD_W         = 24;
    localparam int REL_W           = 26;
    localparam int COEF_W          = 32;
    localparam int PROD_W          = COEF_W + REL_W;
    localparam int DIST_W          = 61;
    localparam int OFFSET_SHIFT    = 8;
    localparam int INDEX_W         = 3;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;
    localparam int PLANE_COUNT_DEF = 6;

    typedef enum logic [0:0] {
        MODE_LOAD = 1'b0,
        MODE_TEST = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        REG_CAM_X = 2'd0,
        REG_CAM_Y = 2'd1,
        REG_CAM_Z = 2'd2
    } reg_idx_t;

    typedef struct packed {
        mode_t                      mode;
        logic [INDEX_W-1:0]         plane_index;
        logic signed [COEF_W-1:0]   coef_a;
        logic signed [COEF_W-1:0]   coef_b;
        logic signed [COEF_W-1:0]   coef_c;
        logic signed [COEF_W-1:0]   coef_d;
        logic signed [REL_W-1:0]    lo_x;
        logic signed [REL_W-1:0]    lo_y;
        logic signed [REL_W-1:0]    lo_z;
        logic signed [REL_W-1:0]    hi_x;
        logic signed [REL_W-1:0]    hi_y;
        logic signed [REL_W-1:0]    hi_z;
        logic                       vis;
    } item_t;

endpackage

[src/bfvt_cell.sv]
// One plane cell: holds a plane, tests the passing box against it, forwards the transaction.
`include "box_frustum_visibility_test_unit_macros.svh"

module bfvt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  bfvt_pkg::item_t up_item,
    output logic            down_valid,
    input  logic            down_ready,
    output bfvt_pkg::item_t down_item
);

    logic signed [bfvt_pkg::COEF_W-1:0] plane_a_reg, plane_a_next;
    logic signed [bfvt_pkg::COEF_W-1:0] plane_b_reg, plane_b_next;
    logic signed [bfvt_pkg::COEF_W-1:0] plane_c_reg, plane_c_next;
    logic signed [bfvt_pkg::COEF_W-1:0] plane_d_reg, plane_d_next;

    logic                               a_valid_reg, a_valid_next;
    bfvt_pkg::item_t                    a_item_reg;
    logic signed [bfvt_pkg::PROD_W-1:0] prod_x_reg, prod_x_next;
    logic signed [bfvt_pkg::PROD_W-1:0] prod_y_reg, prod_y_next;
    logic signed [bfvt_pkg::PROD_W-1:0] prod_z_reg, prod_z_next;
    logic signed [bfvt_pkg::COEF_W-1:0] off_reg;

    logic                               b_valid_reg, b_valid_next;
    bfvt_pkg::item_t                    b_item_reg, b_item_next;

    logic                               a_ready;
    logic                               b_ready;
    logic                               a_accept;
    logic                               b_accept;
    logic                               plane_load;
    logic signed [bfvt_pkg::REL_W-1:0]  px;
    logic signed [bfvt_pkg::REL_W-1:0]  py;
    logic signed [bfvt_pkg::REL_W-1:0]  pz;
    logic signed [bfvt_pkg::DIST_W-1:0] plane_dist;

    assign b_ready    = !b_valid_reg || down_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign a_accept   = up_valid && a_ready;
    assign b_accept   = a_valid_reg && b_ready;
    assign plane_load = a_accept && (up_item.mode == bfvt_pkg::MODE_LOAD)
                        && (up_item.plane_index == bfvt_pkg::INDEX_W'(CELL_INDEX));

    assign up_ready   = a_ready;
    assign down_valid = b_valid_reg;
    assign down_item  = b_item_reg;

    // pick the corner farthest along the plane normal
    always_comb
    begin
        px = plane_a_reg[bfvt_pkg::COEF_W-1] ? up_item.lo_x : up_item.hi_x;
        py = plane_b_reg[bfvt_pkg::COEF_W-1] ? up_item.lo_y : up_item.hi_y;
        pz = plane_c_reg[bfvt_pkg::COEF_W-1] ? up_item.lo_z : up_item.hi_z;
        prod_x_next = plane_a_reg * px;
        prod_y_next = plane_b_reg * py;
        prod_z_next = plane_c_reg * pz;
    end

    always_comb
    begin
        plane_a_next = plane_a_reg;
        plane_b_next = plane_b_reg;
        plane_c_next = plane_c_reg;
        plane_d_next = plane_d_reg;
        if (plane_load)
        begin
            plane_a_next = up_item.coef_a;
            plane_b_next = up_item.coef_b;
            plane_c_next = up_item.coef_c;
            plane_d_next = up_item.coef_d;
        end
    end

    always_comb
    begin
        plane_dist = {{(bfvt_pkg::DIST_W-bfvt_pkg::PROD_W){prod_x_reg[bfvt_pkg::PROD_W-1]}},
                      prod_x_reg}
                   + {{(bfvt_pkg::DIST_W-bfvt_pkg::PROD_W){prod_y_reg[bfvt_pkg::PROD_W-1]}},
                      prod_y_reg}
                   + {{(bfvt_pkg::DIST_W-bfvt_pkg::PROD_W){prod_z_reg[bfvt_pkg::PROD_W-1]}},
                      prod_z_reg}
                   + {{(bfvt_pkg::DIST_W-bfvt_pkg::COEF_W-bfvt_pkg::OFFSET_SHIFT)
                       {off_reg[bfvt_pkg::COEF_W-1]}},
                      off_reg, {bfvt_pkg::OFFSET_SHIFT{1'b0}}};
        b_item_next = a_item_reg;
        if (a_item_reg.mode == bfvt_pkg::MODE_TEST)
        begin
            b_item_next.vis = a_item_reg.vis && !plane_dist[bfvt_pkg::DIST_W-1];
        end
    end

    always_comb
    begin
        a_valid_next = a_ready ? up_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_a_reg <= '0;
            plane_b_reg <= '0;
            plane_c_reg <= '0;
            plane_d_reg <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            plane_a_reg <= plane_a_next;
            plane_b_reg <= plane_b_next;
            plane_c_reg <= plane_c_next;
            plane_d_reg <= plane_d_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_accept)
        begin
            a_item_reg <= up_item;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            off_reg    <= plane_d_reg;
        end
        if (b_accept)
        begin
            b_item_reg <= b_item_next;
        end
    end

    `BFVT_ASSERT_NEXT(a_load_writes_plane, plane_load, plane_a_reg == $past(up_item.coef_a) && plane_d_reg == $past(up_item.coef_d))
    `BFVT_ASSERT_NEXT(b_stall_holds, b_valid_reg && !down_ready, b_valid_reg && $stable(b_item_reg))
    `BFVT_ASSERT_NOW(a_full_when_blocked, a_ready || (a_valid_reg && b_valid_reg))

endmodule

[src/box_frustum_visibility_test_unit.sv]
// Top level of the box frustum visibility test unit: entry stage, plane cell chain, result register.
// A transaction enters each cycle unless item_ready holds it back. Every plane cell spends one
// stage on three coefficient-by-corner multiplies and one on the distance sum and sign test, the
// entry stage forms camera-relative corners, and an output register holds the result.
// Load transactions travel down the same chain and write the plane of the matching cell, so
// loads and tests keep their order; a load gives no result. The plane table is zero after
// reset, and an all-zero plane passes every box. cam_x, cam_y, cam_z sit at 0x0, 0x4, 0x8.
`include "box_frustum_visibility_test_unit_macros.svh"

module box_frustum_visibility_test_unit #(
    parameter int PLANE_COUNT = bfvt_pkg::PLANE_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bfvt_pkg::PADDR_W-1:0]         paddr,
    input  logic [bfvt_pkg::PDATA_W-1:0]         pwdata,
    output logic [bfvt_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic                                 mode,
    input  logic [bfvt_pkg::INDEX_W-1:0]         plane_index,
    input  logic signed [bfvt_pkg::COEF_W-1:0]   coef_a,
    input  logic signed [bfvt_pkg::COEF_W-1:0]   coef_b,
    input  logic signed [bfvt_pkg::COEF_W-1:0]   coef_c,
    input  logic signed [bfvt_pkg::COEF_W-1:0]   coef_d,
    input  logic signed [bfvt_pkg::COORD_W-1:0]  box_x,
    input  logic signed [bfvt_pkg::COORD_W-1:0]  box_y,
    input  logic signed [bfvt_pkg::COORD_W-1:0]  box_z,
    input  logic signed [bfvt_pkg::COORD_W-1:0]  size_x,
    input  logic signed [bfvt_pkg::COORD_W-1:0]  size_y,
    input  logic signed [bfvt_pkg::COORD_W-1:0]  size_z,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic                                 visible
);

    localparam int EXT = bfvt_pkg::REL_W - bfvt_pkg::COORD_W;

    logic signed [bfvt_pkg::COORD_W-1:0] cam_x_reg, cam_x_next;
    logic signed [bfvt_pkg::COORD_W-1:0] cam_y_reg, cam_y_next;
    logic signed [bfvt_pkg::COORD_W-1:0] cam_z_reg, cam_z_next;

    logic                cfg_write;
    bfvt_pkg::reg_idx_t  cfg_idx;

    logic                entry_valid_reg, entry_valid_next;
    bfvt_pkg::item_t     entry_item_next;
    bfvt_pkg::item_t     entry_item_reg;
    logic                entry_ready;

    logic                link_valid [0:PLANE_COUNT];
    logic                link_ready [0:PLANE_COUNT];
    bfvt_pkg::item_t     link_item  [0:PLANE_COUNT];

    logic                out_valid_reg, out_valid_next;
    logic                visible_reg;
    logic                tail_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = bfvt_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cam_x_next = cam_x_reg;
        cam_y_next = cam_y_reg;
        cam_z_next = cam_z_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                bfvt_pkg::REG_CAM_X: cam_x_next = pwdata[bfvt_pkg::COORD_W-1:0];
                bfvt_pkg::REG_CAM_Y: cam_y_next = pwdata[bfvt_pkg::COORD_W-1:0];
                bfvt_pkg::REG_CAM_Z: cam_z_next = pwdata[bfvt_pkg::COORD_W-1:0];
                default:             cam_x_next = cam_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bfvt_pkg::REG_CAM_X:
                prdata = {{(bfvt_pkg::PDATA_W-bfvt_pkg::COORD_W){cam_x_reg[bfvt_pkg::COORD_W-1]}},
                          cam_x_reg};
            bfvt_pkg::REG_CAM_Y:
                prdata = {{(bfvt_pkg::PDATA_W-bfvt_pkg::COORD_W){cam_y_reg[bfvt_pkg::COORD_W-1]}},
                          cam_y_reg};
            bfvt_pkg::REG_CAM_Z:
                prdata = {{(bfvt_pkg::PDATA_W-bfvt_pkg::COORD_W){cam_z_reg[bfvt_pkg::COORD_W-1]}},
                          cam_z_reg};
            default:
                prdata = '0;
        endcase
    end

    // move the box into camera-relative space
    always_comb
    begin
        entry_item_next             = '0;
        entry_item_next.mode        = bfvt_pkg::mode_t'(mode);
        entry_item_next.plane_index = plane_index;
        entry_item_next.coef_a      = coef_a;
        entry_item_next.coef_b      = coef_b;
        entry_item_next.coef_c      = coef_c;
        entry_item_next.coef_d      = coef_d;
        entry_item_next.lo_x = {{EXT{box_x[bfvt_pkg::COORD_W-1]}}, box_x}
                             - {{EXT{cam_x_reg[bfvt_pkg::COORD_W-1]}}, cam_x_reg};
        entry_item_next.lo_y = {{EXT{box_y[bfvt_pkg::COORD_W-1]}}, box_y}
                             - {{EXT{cam_y_reg[bfvt_pkg::COORD_W-1]}}, cam_y_reg};
        entry_item_next.lo_z = {{EXT{box_z[bfvt_pkg::COORD_W-1]}}, box_z}
                             - {{EXT{cam_z_reg[bfvt_pkg::COORD_W-1]}}, cam_z_reg};
        entry_item_next.hi_x = entry_item_next.lo_x
                             + {{EXT{size_x[bfvt_pkg::COORD_W-1]}}, size_x};
        entry_item_next.hi_y = entry_item_next.lo_y
                             + {{EXT{size_y[bfvt_pkg::COORD_W-1]}}, size_y};
        entry_item_next.hi_z = entry_item_next.lo_z
                             + {{EXT{size_z[bfvt_pkg::COORD_W-1]}}, size_z};
        entry_item_next.vis  = 1'b1;
    end

    assign entry_ready      = !entry_valid_reg || link_ready[0];
    assign item_ready       = entry_ready;
    assign entry_valid_next = entry_ready ? item_valid : entry_valid_reg;

    assign link_valid[0] = entry_valid_reg;
    assign link_item[0]  = entry_item_reg;

    genvar gi;
    generate
        for (gi = 0; gi < PLANE_COUNT; gi++)
        begin : g_cell
            bfvt_cell #(
                .CELL_INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .up_valid   (link_valid[gi]),
                .up_ready   (link_ready[gi]),
                .up_item    (link_item[gi]),
                .down_valid (link_valid[gi+1]),
                .down_ready (link_ready[gi+1]),
                .down_item  (link_item[gi+1])
            );
        end
    endgenerate

    // drop load transactions at the tail, register test results
    assign link_ready[PLANE_COUNT] = !out_valid_reg || result_ready;
    assign tail_take = link_valid[PLANE_COUNT] && link_ready[PLANE_COUNT]
                       && (link_item[PLANE_COUNT].mode == bfvt_pkg::MODE_TEST);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (link_ready[PLANE_COUNT])
        begin
            out_valid_next = tail_take;
        end
    end

    assign result_valid = out_valid_reg;
    assign visible      = visible_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg       <= '0;
            cam_y_reg       <= '0;
            cam_z_reg       <= '0;
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cam_x_reg       <= cam_x_next;
            cam_y_reg       <= cam_y_next;
            cam_z_reg       <= cam_z_next;
            entry_valid_reg <= entry_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && entry_ready)
        begin
            entry_item_reg <= entry_item_next;
        end
        if (tail_take)
        begin
            visible_reg <= link_item[PLANE_COUNT].vis;
        end
    end

    `BFVT_ASSERT_NEXT(cam_x_written, cfg_write && cfg_idx == bfvt_pkg::REG_CAM_X, cam_x_reg == $past(pwdata[bfvt_pkg::COORD_W-1:0]))
    `BFVT_ASSERT_NEXT(cam_held_without_write, !cfg_write, $stable(cam_x_reg) && $stable(cam_y_reg) && $stable(cam_z_reg))
    `BFVT_ASSERT_NEXT(load_gives_no_result, link_valid[PLANE_COUNT] && link_item[PLANE_COUNT].mode == bfvt_pkg::MODE_LOAD && !out_valid_reg, !out_valid_reg)

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the box frustum visibility test unit.
module testbench;
    import bfvt_pkg::*;

    localparam int PLANE_COUNT  = PLANE_COUNT_DEF;
    localparam int PIPE_LATENCY = 2 + 2 * PLANE_COUNT;
    localparam int RANDOM_ITEMS = 305;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam logic signed [COEF_W-1:0]  COEF_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [COEF_W-1:0]  COEF_MIN  = 32'sh80000000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef struct {
        mode_t                     mode;
        logic [INDEX_W-1:0]        plane_index;
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [COEF_W-1:0]  c;
        logic signed [COEF_W-1:0]  d;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        bit                        hold_for_drain;
    } cull_request_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [PADDR_W-1:0]          paddr = '0;
    logic [PDATA_W-1:0]          pwdata = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        item_valid = 1'b0;
    logic                        item_ready;
    logic                        mode = 1'b0;
    logic [INDEX_W-1:0]          plane_index = '0;
    logic signed [COEF_W-1:0]    coef_a = '0;
    logic signed [COEF_W-1:0]    coef_b = '0;
    logic signed [COEF_W-1:0]    coef_c = '0;
    logic signed [COEF_W-1:0]    coef_d = '0;
    logic signed [COORD_W-1:0]   box_x = '0;
    logic signed [COORD_W-1:0]   box_y = '0;
    logic signed [COORD_W-1:0]   box_z = '0;
    logic signed [COORD_W-1:0]   size_x = '0;
    logic signed [COORD_W-1:0]   size_y = '0;
    logic signed [COORD_W-1:0]   size_z = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic                        visible;

    logic signed [COORD_W-1:0]   cam_x = '0;
    logic signed [COORD_W-1:0]   cam_y = '0;
    logic signed [COORD_W-1:0]   cam_z = '0;
    logic signed [COEF_W-1:0]    normal_x [PLANE_COUNT];
    logic signed [COEF_W-1:0]    normal_y [PLANE_COUNT];
    logic signed [COEF_W-1:0]    normal_z [PLANE_COUNT];
    logic signed [COEF_W-1:0]    offset   [PLANE_COUNT];

    cull_request_t cull_requests [$];
    logic          expected_visible [$];
    int            sender_idle_pct = 0;
    int            receiver_idle_pct = 0;
    int            error_count = 0;

    box_frustum_visibility_test_unit #(
        .PLANE_COUNT(PLANE_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .mode(mode),
        .plane_index(plane_index),
        .coef_a(coef_a),
        .coef_b(coef_b),
        .coef_c(coef_c),
        .coef_d(coef_d),
        .box_x(box_x),
        .box_y(box_y),
        .box_z(box_z),
        .size_x(size_x),
        .size_y(size_y),
        .size_z(size_z),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .visible(visible)
    );

    initial
    begin
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            normal_x[i] = '0;
            normal_y[i] = '0;
            normal_z[i] = '0;
            offset[i]   = '0;
        end
    end

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void predict_visibility();
        logic signed [REL_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
        logic signed [REL_W-1:0] pick_x, pick_y, pick_z;
        longint                  plane_dist;
        logic                    vis;
        if (mode == MODE_LOAD)
        begin
            if (plane_index < PLANE_COUNT)
            begin
                normal_x[plane_index] = coef_a;
                normal_y[plane_index] = coef_b;
                normal_z[plane_index] = coef_c;
                offset[plane_index]   = coef_d;
            end
        end
        else
        begin
            lo_x = box_x - cam_x;
            lo_y = box_y - cam_y;
            lo_z = box_z - cam_z;
            hi_x = lo_x + size_x;
            hi_y = lo_y + size_y;
            hi_z = lo_z + size_z;
            vis = 1'b1;
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                pick_x = (normal_x[i] >= 0) ? hi_x : lo_x;
                pick_y = (normal_y[i] >= 0) ? hi_y : lo_y;
                pick_z = (normal_z[i] >= 0) ? hi_z : lo_z;
                plane_dist = longint'(normal_x[i]) * longint'(pick_x)
                           + longint'(normal_y[i]) * longint'(pick_y)
                           + longint'(normal_z[i]) * longint'(pick_z)
                           + longint'(offset[i]) * 256;
                if (plane_dist < 0)
                    vis = 1'b0;
            end
            expected_visible.push_back(vis);
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return COORD_W'($urandom_range(0, 8191) - 4096);
        else if (sel < 8)
            return COORD_W'($urandom());
        else if (sel == 8)
            return COORD_MAX;
        else
            return COORD_MIN;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return COORD_W'($urandom_range(0, 2048));
        else if (sel < 8)
            return COORD_W'(-$urandom_range(1, 2048));
        else if (sel == 8)
            return COORD_W'($urandom());
        else
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return '0;
        else if (sel < 6)
            return $urandom_range(0, 262143) - 131072;
        else if (sel < 8)
            return $urandom();
        else
        begin
            case ($urandom_range(0, 3))
                0: return COEF_MAX;
                1: return COEF_MIN;
                2: return 32'sd1;
                default: return -32'sd1;
            endcase
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_offset();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom_range(0, 32'h3FFFFFFF);
        else if (sel < 6)
            return $urandom_range(0, 262143) - 131072;
        else if (sel < 9)
            return $urandom();
        else
            return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
    endfunction

    task automatic queue_load(input logic [INDEX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] a,
                              input logic signed [COEF_W-1:0] b,
                              input logic signed [COEF_W-1:0] c,
                              input logic signed [COEF_W-1:0] d);
        cull_request_t req;
        req.mode = MODE_LOAD;
        req.plane_index = idx;
        req.a = a;
        req.b = b;
        req.c = c;
        req.d = d;
        req.bx = COORD_W'($urandom());
        req.by = COORD_W'($urandom());
        req.bz = COORD_W'($urandom());
        req.sx = COORD_W'($urandom());
        req.sy = COORD_W'($urandom());
        req.sz = COORD_W'($urandom());
        req.hold_for_drain = ($urandom_range(0, 99) == 0);
        cull_requests.push_back(req);
    endtask

    task automatic queue_test(input logic signed [COORD_W-1:0] bx,
                              input logic signed [COORD_W-1:0] by,
                              input logic signed [COORD_W-1:0] bz,
                              input logic signed [COORD_W-1:0] sx,
                              input logic signed [COORD_W-1:0] sy,
                              input logic signed [COORD_W-1:0] sz);
        cull_request_t req;
        req.mode = MODE_TEST;
        req.plane_index = INDEX_W'($urandom());
        req.a = $urandom();
        req.b = $urandom();
        req.c = $urandom();
        req.d = $urandom();
        req.bx = bx;
        req.by = by;
        req.bz = bz;
        req.sx = sx;
        req.sy = sy;
        req.sz = sz;
        req.hold_for_drain = ($urandom_range(0, 99) == 0);
        cull_requests.push_back(req);
    endtask

    task automatic queue_random_plane(input logic [INDEX_W-1:0] idx);
        if ($urandom_range(0, 9) < 3)
            queue_load(idx, '0, '0, '0, '0);
        else
            queue_load(idx, rand_coef(), rand_coef(), rand_coef(), rand_offset());
    endtask

    task automatic queue_random_traffic(input int count);
        int done;
        int run;
        int sel;
        done = 0;
        while (done < count)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                for (int i = 0; i < PLANE_COUNT; i++)
                    queue_random_plane(INDEX_W'(i));
                done += PLANE_COUNT;
            end
            else if (sel < 4)
            begin
                if ($urandom_range(0, 6) == 0)
                    queue_random_plane(INDEX_W'($urandom_range(PLANE_COUNT, 7)));
                else
                begin
                    queue_random_plane(INDEX_W'($urandom_range(0, PLANE_COUNT - 1)));
                    done++;
                end
            end
            else
            begin
                run = $urandom_range(1, 12);
                for (int i = 0; i < run; i++)
                begin
                    if ($urandom_range(0, 9) < 3)
                        queue_test(cam_x + rand_coord(), cam_y + rand_coord(),
                                   cam_z + rand_coord(), rand_size(), rand_size(),
                                   rand_size());
                    else
                        queue_test(rand_coord(), rand_coord(), rand_coord(),
                                   rand_size(), rand_size(), rand_size());
                end
                done += run;
            end
        end
    endtask

    task automatic write_camera_reg(input logic [1:0] idx, input logic [COORD_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {8'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CAM_X: cam_x = value;
            REG_CAM_Y: cam_y = value;
            REG_CAM_Z: cam_z = value;
            default: ;
        endcase
    endtask

    task automatic wait_for_idle();
        while (cull_requests.size() != 0 || item_valid || expected_visible.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 6) @(posedge clk);
    endtask

    task automatic queue_directed();
        queue_test('0, '0, '0, '0, '0, '0);
        queue_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_load(3'd6, '0, '0, '0, -32'sd1);
        queue_load(3'd7, '0, '0, '0, -32'sd1);
        queue_test('0, '0, '0, 24'sd1, 24'sd1, 24'sd1);
        queue_load(3'd0, 32'sd65536, '0, '0, '0);
        queue_test(-24'sd256, '0, '0, 24'sd512, '0, '0);
        queue_test(-24'sd256, '0, '0, -24'sd256, '0, '0);
        queue_test('0, '0, '0, '0, '0, '0);
        queue_load(3'd1, -32'sd65536, '0, '0, 32'sd65536);
        queue_test(24'sd256, '0, '0, '0, '0, '0);
        queue_test(24'sd257, '0, '0, '0, '0, '0);
        queue_load(3'd2, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MAX);
        queue_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_load(3'd3, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        queue_test(COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
        queue_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_load(3'd5, '0, '0, '0, -32'sd1);
        queue_test('0, '0, '0, '0, '0, '0);
        queue_load(3'd5, '0, '0, '0, '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_visibility();
            if (!item_valid || item_ready)
            begin
                if (cull_requests.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct
                    && !(cull_requests[0].hold_for_drain && expected_visible.size() != 0))
                begin
                    item_valid <= 1'b1;
                    mode <= cull_requests[0].mode;
                    plane_index <= cull_requests[0].plane_index;
                    coef_a <= cull_requests[0].a;
                    coef_b <= cull_requests[0].b;
                    coef_c <= cull_requests[0].c;
                    coef_d <= cull_requests[0].d;
                    box_x <= cull_requests[0].bx;
                    box_y <= cull_requests[0].by;
                    box_z <= cull_requests[0].bz;
                    size_x <= cull_requests[0].sx;
                    size_y <= cull_requests[0].sy;
                    size_z <= cull_requests[0].sz;
                    void'(cull_requests.pop_front());
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_visible.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: visible=%b", visible);
            end
            else
            begin
                if (visible !== expected_visible[0])
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("visible mismatch: expected %b, actual %b",
                                 expected_visible[0], visible);
                end
                void'(expected_visible.pop_front());
            end
        end
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    sender_idle_pct = 14;
                    receiver_idle_pct = 63;
                end
                1:
                begin
                    sender_idle_pct = 63;
                    receiver_idle_pct = 14;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            case (phase)
                0:
                begin
                    write_camera_reg(REG_CAM_X, '0);
                    write_camera_reg(REG_CAM_Y, '0);
                    write_camera_reg(REG_CAM_Z, '0);
                end
                1:
                begin
                    write_camera_reg(REG_CAM_X, COORD_MAX);
                    write_camera_reg(REG_CAM_Y, COORD_MAX);
                    write_camera_reg(REG_CAM_Z, COORD_MAX);
                end
                2:
                begin
                    write_camera_reg(REG_CAM_X, COORD_MIN);
                    write_camera_reg(REG_CAM_Y, COORD_MIN);
                    write_camera_reg(REG_CAM_Z, COORD_MIN);
                end
                4:
                begin
                    write_camera_reg(REG_CAM_X, COORD_MAX);
                    write_camera_reg(REG_CAM_Y, COORD_MIN);
                    write_camera_reg(REG_CAM_Z, '0);
                end
                default:
                begin
                    write_camera_reg(REG_CAM_X, COORD_W'($urandom_range(0, 8191) - 4096));
                    write_camera_reg(REG_CAM_Y, COORD_W'($urandom()));
                    write_camera_reg(REG_CAM_Z, COORD_W'($urandom_range(0, 8191) - 4096));
                    write_camera_reg(REG_UNMAPPED, COORD_W'($urandom()));
                end
            endcase
            if (phase == 0)
                queue_directed();
            queue_random_traffic(RANDOM_ITEMS);
            wait_for_idle();
        end
        if (error_count == 0 && expected_visible.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
